FILE: hdl/deque_with_running_total_assert.svh
// Assertion macros for the deque with running total.
`ifndef DEQUE_WITH_RUNNING_TOTAL_ASSERT_SVH
`define DEQUE_WITH_RUNNING_TOTAL_ASSERT_SVH

`ifndef SYNTHESIS
`define DWRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deque assertion failed");
`define DWRT_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("deque assertion failed");
`else
`define DWRT_ASSERT(lbl, prop)
`define DWRT_ASSERT_NR(lbl, prop)
`endif

`endif

FILE: hdl/dwrt_pkg.sv
`default_nettype none

package dwrt_pkg;

  localparam int DepthDefault   = 16;
  localparam int TagBitsDefault = 16;

  localparam int ModeW   = 3;
  localparam int PriceW  = 20;
  localparam int TotalW  = 24;
  localparam int StatusW = 2;

  localparam logic [ModeW-1:0] ModePushFront = 3'd0;
  localparam logic [ModeW-1:0] ModePushBack  = 3'd1;
  localparam logic [ModeW-1:0] ModePopFront  = 3'd2;
  localparam logic [ModeW-1:0] ModePopBack   = 3'd3;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } op_t;

endpackage

`default_nettype wire

FILE: hdl/dwrt_cell.sv
`default_nettype none

module dwrt_cell #(
  parameter int TAG_BITS = dwrt_pkg::TagBitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dwrt_pkg::op_t              op_i,
  input  wire logic [dwrt_pkg::PriceW-1:0] new_price_i,
  input  wire logic [TAG_BITS-1:0]        new_tag_i,
  input  wire logic                       left_occ_i,
  input  wire logic [dwrt_pkg::PriceW-1:0] left_price_i,
  input  wire logic [TAG_BITS-1:0]        left_tag_i,
  input  wire logic                       right_occ_i,
  input  wire logic [dwrt_pkg::PriceW-1:0] right_price_i,
  input  wire logic [TAG_BITS-1:0]        right_tag_i,
  output logic                            occ_o,
  output logic [dwrt_pkg::PriceW-1:0]     price_o,
  output logic [TAG_BITS-1:0]             tag_o,
  output logic                            last_o
);
  import dwrt_pkg::*;

  logic                occ_q, occ_d;
  logic [PriceW-1:0]   price_q, price_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  always_comb begin
    occ_d   = occ_q;
    price_d = price_q;
    tag_d   = tag_q;
    if (op_i.push_front) begin
      occ_d   = left_occ_i;
      price_d = left_price_i;
      tag_d   = left_tag_i;
    end else if (op_i.push_back && !occ_q && left_occ_i) begin
      occ_d   = 1'b1;
      price_d = new_price_i;
      tag_d   = new_tag_i;
    end else if (op_i.pop_front) begin
      occ_d   = right_occ_i;
      price_d = right_price_i;
      tag_d   = right_tag_i;
    end else if (op_i.pop_back && occ_q && !right_occ_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    tag_q   <= tag_d;
  end

  assign occ_o   = occ_q;
  assign price_o = price_q;
  assign tag_o   = tag_q;
  assign last_o  = occ_q & ~right_occ_i;

endmodule

`default_nettype wire

FILE: hdl/deque_with_running_total.sv
`default_nettype none

// Bounded double-ended queue of (price, tag) entries with a running price total.
// Entries live in a row of DEPTH cells, front at cell 0; a front push or pop
// shifts the whole row by one cell, a back push or pop touches only one cell
// at the back end of the occupied run. At most one request is taken per cycle:
// its result (status, count, total, front and back entries) is offered in the
// cycle after acceptance and the next request is taken in the same cycle that
// result is taken, so with out_ready_i high it sustains one request per clock.
// The back entry is picked from the row by an AND-OR select across all cells.
module deque_with_running_total #(
  parameter int DEPTH    = dwrt_pkg::DepthDefault,
  parameter int TAG_BITS = dwrt_pkg::TagBitsDefault,
  parameter int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [dwrt_pkg::ModeW-1:0]   mode_i,
  input  wire logic [dwrt_pkg::PriceW-1:0]  price_i,
  input  wire logic [TAG_BITS-1:0]          item_tag_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [dwrt_pkg::StatusW-1:0]      status_o,
  output logic [CNT_W-1:0]                  entry_count_o,
  output logic [dwrt_pkg::TotalW-1:0]       price_total_o,
  output logic [dwrt_pkg::PriceW-1:0]       front_price_o,
  output logic [TAG_BITS-1:0]               front_tag_o,
  output logic [dwrt_pkg::PriceW-1:0]       back_price_o,
  output logic [TAG_BITS-1:0]               back_tag_o
);
  import dwrt_pkg::*;

  logic [DEPTH-1:0]    occ_w;
  logic [DEPTH-1:0]    last_w;
  logic [PriceW-1:0]   price_w [DEPTH];
  logic [TAG_BITS-1:0] tag_w   [DEPTH];

  logic                accept;
  logic                full, empty;
  op_t                 op;
  status_e             status_d, status_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic                out_valid_q;
  logic [PriceW-1:0]   back_price;
  logic [TAG_BITS-1:0] back_tag;

  assign full   = occ_w[DEPTH-1];
  assign empty  = ~occ_w[0];
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    op       = '0;
    status_d = StatusOk;
    case (mode_i)
      ModePushFront, ModePushBack: begin
        if (full) begin
          status_d = StatusFull;
        end else begin
          op.push_front = accept & (mode_i == ModePushFront) & ~empty;
          op.push_back  = accept & ((mode_i == ModePushBack) | empty);
        end
      end
      ModePopFront, ModePopBack: begin
        if (empty) begin
          status_d = StatusEmpty;
        end else begin
          op.pop_front = accept & (mode_i == ModePopFront) & ~last_w[0];
          op.pop_back  = accept & ((mode_i == ModePopBack) | last_w[0]);
        end
      end
      default: begin
        status_d = StatusOk;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                left_occ, right_occ;
    logic [PriceW-1:0]   left_price, right_price;
    logic [TAG_BITS-1:0] left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_occ   = 1'b1;
      assign left_price = price_i;
      assign left_tag   = item_tag_i;
    end else begin : g_mid
      assign left_occ   = occ_w[i-1];
      assign left_price = price_w[i-1];
      assign left_tag   = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_occ   = 1'b0;
      assign right_price = '0;
      assign right_tag   = '0;
    end else begin : g_inner
      assign right_occ   = occ_w[i+1];
      assign right_price = price_w[i+1];
      assign right_tag   = tag_w[i+1];
    end

    dwrt_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .new_price_i  (price_i),
      .new_tag_i    (item_tag_i),
      .left_occ_i   (left_occ),
      .left_price_i (left_price),
      .left_tag_i   (left_tag),
      .right_occ_i  (right_occ),
      .right_price_i(right_price),
      .right_tag_i  (right_tag),
      .occ_o        (occ_w[i]),
      .price_o      (price_w[i]),
      .tag_o        (tag_w[i]),
      .last_o       (last_w[i])
    );
  end

  always_comb begin
    back_price = '0;
    back_tag   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_price = back_price | (price_w[i] & {PriceW{last_w[i]}});
      back_tag   = back_tag | (tag_w[i] & {TAG_BITS{last_w[i]}});
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    total_d = total_q;
    if (op.push_front || op.push_back) begin
      cnt_d   = cnt_q + CNT_W'(1);
      total_d = total_q + TotalW'(price_i);
    end else if (op.pop_front) begin
      cnt_d   = cnt_q - CNT_W'(1);
      total_d = total_q - TotalW'(price_w[0]);
    end else if (op.pop_back) begin
      cnt_d   = cnt_q - CNT_W'(1);
      total_d = total_q - TotalW'(back_price);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      status_q    <= StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      total_q <= total_d;
      if (accept) begin
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_q;
  assign price_total_o = total_q;
  assign front_price_o = price_w[0] & {PriceW{occ_w[0]}};
  assign front_tag_o   = tag_w[0] & {TAG_BITS{occ_w[0]}};
  assign back_price_o  = back_price;
  assign back_tag_o    = back_tag;

`include "deque_with_running_total_assert.svh"

  `DWRT_ASSERT(a_cnt_matches_occ, $countones(occ_w) == int'(cnt_q))
  `DWRT_ASSERT(a_occ_contiguous, ((occ_w >> 1) & ~occ_w) == '0)
  `DWRT_ASSERT(a_hold_while_stalled, out_valid_q && !out_ready_i |=> $stable(cnt_q) && $stable(total_q) && $stable(occ_w))
  `DWRT_ASSERT(a_empty_total_zero, cnt_q == '0 |-> total_q == '0)
  `DWRT_ASSERT(a_single_last, $onehot0(last_w))

endmodule

`default_nettype wire

FILE: tb/deque_with_running_total_test.sv
module deque_with_running_total_test;
  import dwrt_pkg::*;

  localparam int Depth  = 16;
  localparam int TagW   = 16;
  localparam int CountW = 5;
  localparam int PhaseItems = 240;

  localparam logic [ModeW-1:0] ModeQuery      = 3'd4;
  localparam logic [ModeW-1:0] ModeSpareFirst = 3'd5;
  localparam logic [ModeW-1:0] ModeSpareLast  = 3'd7;
  localparam logic [PriceW-1:0] PriceMax = '1;
  localparam logic [TagW-1:0]   TagMax   = '1;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic [PriceW-1:0] price;
    logic [TagW-1:0]   tag;
    bit                drain;
  } deque_req_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
    logic [TotalW-1:0] total;
    logic [PriceW-1:0] front_price;
    logic [TagW-1:0]   front_tag;
    logic [PriceW-1:0] back_price;
    logic [TagW-1:0]   back_tag;
  } deque_view_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ModeW-1:0]  mode_i = '0;
  logic [PriceW-1:0] price_i = '0;
  logic [TagW-1:0]   item_tag_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0] entry_count_o;
  logic [TotalW-1:0] price_total_o;
  logic [PriceW-1:0] front_price_o;
  logic [TagW-1:0]   front_tag_o;
  logic [PriceW-1:0] back_price_o;
  logic [TagW-1:0]   back_tag_o;

  deque_req_t  req_backlog[$];
  deque_view_t view_expected[$];
  bit          req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatch_count = 0;

  logic [PriceW-1:0] shelf_price[Depth];
  logic [TagW-1:0]   shelf_tag[Depth];
  logic [3:0]        head_slot = '0;
  logic [3:0]        tail_slot = '0;
  logic [CountW-1:0] held = '0;
  logic [TotalW-1:0] total_sum = '0;

  deque_with_running_total dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .price_i       (price_i),
    .item_tag_i    (item_tag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .price_total_o (price_total_o),
    .front_price_o (front_price_o),
    .front_tag_o   (front_tag_o),
    .back_price_o  (back_price_o),
    .back_tag_o    (back_tag_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic deque_view_t apply_request(input logic [ModeW-1:0] mode,
                                                input logic [PriceW-1:0] price,
                                                input logic [TagW-1:0] tag);
    deque_view_t v;
    logic [3:0]  slot;
    v = '0;
    v.status = StatusOk;
    if (mode == ModePushFront || mode == ModePushBack) begin
      if (held == Depth) begin
        v.status = StatusFull;
      end else begin
        if (held == 0) begin
          slot = head_slot;
          tail_slot = slot;
        end else if (mode == ModePushFront) begin
          slot = head_slot - 4'd1;
          head_slot = slot;
        end else begin
          slot = tail_slot + 4'd1;
          tail_slot = slot;
        end
        shelf_price[slot] = price;
        shelf_tag[slot] = tag;
        held = held + 1'b1;
        total_sum = total_sum + price;
      end
    end else if (mode == ModePopFront || mode == ModePopBack) begin
      if (held == 0) begin
        v.status = StatusEmpty;
      end else begin
        slot = (mode == ModePopFront) ? head_slot : tail_slot;
        total_sum = total_sum - shelf_price[slot];
        held = held - 1'b1;
        if (held != 0) begin
          if (mode == ModePopFront) head_slot = head_slot + 4'd1;
          else tail_slot = tail_slot - 4'd1;
        end
      end
    end
    v.count = held;
    v.total = total_sum;
    if (held != 0) begin
      v.front_price = shelf_price[head_slot];
      v.front_tag = shelf_tag[head_slot];
      v.back_price = shelf_price[tail_slot];
      v.back_tag = shelf_tag[tail_slot];
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    deque_view_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (view_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d count %0d total %h",
                     status_o, entry_count_o, price_total_o);
        end else begin
          want = view_expected.pop_front();
          if (status_o !== want.status || entry_count_o !== want.count ||
              price_total_o !== want.total || front_price_o !== want.front_price ||
              front_tag_o !== want.front_tag || back_price_o !== want.back_price ||
              back_tag_o !== want.back_tag) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch expected: st %0d cnt %0d tot %h front %h/%h back %h/%h",
                       want.status, want.count, want.total, want.front_price,
                       want.front_tag, want.back_price, want.back_tag);
              $display("         actual:   st %0d cnt %0d tot %h front %h/%h back %h/%h",
                       status_o, entry_count_o, price_total_o, front_price_o,
                       front_tag_o, back_price_o, back_tag_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o)
        view_expected.push_back(apply_request(mode_i, price_i, item_tag_i));
    end
    req_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid_i || req_taken) begin
        if (req_backlog.size() != 0 &&
            !(req_backlog[0].drain && view_expected.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          mode_i <= req_backlog[0].mode;
          price_i <= req_backlog[0].price;
          item_tag_i <= req_backlog[0].tag;
          in_valid_i <= 1'b1;
          void'(req_backlog.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic add_request(input logic [ModeW-1:0] mode, input logic [PriceW-1:0] price,
                             input logic [TagW-1:0] tag, input bit drain);
    deque_req_t r;
    r.mode = mode;
    r.price = price;
    r.tag = tag;
    r.drain = drain;
    req_backlog.push_back(r);
  endtask

  function automatic logic [PriceW-1:0] pick_price();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return PriceMax;
    return PriceW'($urandom);
  endfunction

  task automatic queue_random_traffic(input int n, input int drain_at);
    int added;
    int push_pct;
    int burst;
    int r;
    logic [ModeW-1:0] mode;
    added = 0;
    while (added < n) begin
      case ($urandom_range(2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        r = $urandom_range(99);
        if (r < 5) begin
          mode = ModeW'($urandom_range(ModeSpareLast, ModeSpareFirst));
        end else begin
          if (r < 15) mode = ModeQuery;
          else if ($urandom_range(99) < push_pct)
            mode = $urandom_range(1) ? ModePushFront : ModePushBack;
          else
            mode = $urandom_range(1) ? ModePopFront : ModePopBack;
          added++;
        end
        add_request(mode, pick_price(), TagW'($urandom), added == drain_at);
      end
    end
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid_i || view_expected.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 68;
    add_request(ModeQuery, PriceMax, TagMax, 1'b0);
    add_request(ModePopFront, '0, '0, 1'b0);
    add_request(ModePopBack, '0, '0, 1'b0);
    for (i = 0; i < Depth; i++)
      add_request(i[0] ? ModePushFront : ModePushBack, PriceMax,
                  i[0] ? TagMax : TagW'(i), 1'b0);
    add_request(ModePushFront, 20'h12345, 16'h5a5a, 1'b0);
    add_request(ModePushBack, '0, '0, 1'b0);
    for (i = ModeSpareFirst; i <= ModeSpareLast; i++)
      add_request(ModeW'(i), PriceW'($urandom), TagW'($urandom), 1'b0);
    queue_random_traffic(PhaseItems, PhaseItems / 2);
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 20;
    queue_random_traffic(PhaseItems, -1);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(PhaseItems, -1);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dwrt_pkg.sv
hdl/dwrt_cell.sv
hdl/deque_with_running_total.sv
tb/deque_with_running_total_test.sv
